### hdl/lsbgf_pkg.sv
// Shared constants, types, microcode table and bin helpers for the scan binning block.
package lsbgf_pkg;

  // Geometry
  localparam int BIN_COUNT = 360;
  localparam int BIN_W     = $clog2(BIN_COUNT);
  localparam int BIN_MAX   = BIN_COUNT - 1;

  // Field widths
  localparam int OP_W      = 2;
  localparam int ANGLE_W   = 16;
  localparam int DIST_IN_W = 18;
  localparam int QUAL_W    = 8;
  localparam int FLAG_W    = 8;
  localparam int IDX_W     = 9;
  localparam int DIST_W    = 13;
  localparam int STAT_W    = 2;

  // Configuration
  localparam int THR_W       = 8;
  localparam int REACH_W     = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(60);
  localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(8);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAL_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REACH    = CFG_IDX_W'(1);

  // Degree from angle: (angle * 90) >> 14
  localparam int DEG_SCALE   = 90;
  localparam int DEG_SCALE_W = 7;
  localparam int DEG_FRAC    = 14;
  localparam int DEG_PROD_W  = ANGLE_W + DEG_SCALE_W;
  localparam int DEG_W       = DEG_PROD_W - DEG_FRAC;

  // dist / 40 = ((dist >> 3) * 52429) >> 18, exact over the input range
  localparam int DIV_PRE_SHIFT = 3;
  localparam int DIV_Y_W       = DIST_IN_W - DIV_PRE_SHIFT;
  localparam int DIV5_MUL      = 52429;
  localparam int DIV5_MUL_W    = 16;
  localparam int DIV5_SHIFT    = 18;
  localparam int DIV_PROD_W    = DIV_Y_W + DIV5_MUL_W;

  // Compare width for degree and query index against the bin count
  localparam int CMP_W = ((BIN_W > IDX_W) ? BIN_W : IDX_W) + 1;

  // Memory word: {measured, distance}
  localparam int MEM_W = DIST_W + 1;

  // Stream packing
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = OP_W;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = STAT_W;
  localparam int OFS_ANGLE = 0;
  localparam int OFS_DIST  = OFS_ANGLE + ANGLE_W;
  localparam int OFS_QUAL  = OFS_DIST + DIST_IN_W;
  localparam int OFS_FLAG  = OFS_QUAL + QUAL_W;
  localparam int OFS_IDX   = OFS_FLAG + FLAG_W;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_MEASURED = 2'd0,
    ST_FILLED   = 2'd1,
    ST_EMPTY    = 2'd2
  } bin_status_e;

  // Microprogram steps
  typedef enum logic [3:0] {
    P_IDLE    = 4'd0,
    P_SMP_MUL = 4'd1,
    P_SMP_WR  = 4'd2,
    P_CLR     = 4'd3,
    P_Q0      = 4'd4,
    P_Q1      = 4'd5,
    P_FI      = 4'd6,
    P_FWD     = 4'd7,
    P_BI      = 4'd8,
    P_BWD     = 4'd9,
    P_AVG     = 4'd10,
    P_MEAS    = 4'd11,
    P_EMPTY   = 4'd12,
    P_OUT     = 4'd13
  } step_e;

  typedef enum logic [3:0] {
    CND_ALWAYS,
    CND_BEAT,
    CND_CLR_LAST,
    CND_IDX_BAD,
    CND_HIT,
    CND_LIM0,
    CND_HIT_LOOP,
    CND_OUT_FREE
  } cond_e;

  typedef enum logic [2:0] {
    RA_IDX,
    RA_NEXT_IDX,
    RA_PREV_IDX,
    RA_NEXT_POS,
    RA_PREV_POS
  } ra_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SAMPLE,
    WR_CLEAR
  } wr_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_NEXT_IDX,
    POS_PREV_IDX,
    POS_NEXT,
    POS_PREV
  } pos_e;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_FWD,
    CAP_VAL
  } cap_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_MEAS,
    RES_AVG,
    RES_EMPTY
  } res_e;

  typedef struct packed {
    logic  s_ready;
    logic  in_ld;
    cond_e cond;
    step_e jmp;
    step_e nxt;
    ra_e   ra;
    wr_e   wr;
    pos_e  pos;
    logic  cnt_ld;
    logic  cnt_dec;
    cap_e  cap;
    res_e  res;
    logic  mul_ld;
    logic  clr_inc;
    logic  out_ld;
  } ucode_t;

  typedef struct packed {
    logic beat;
    logic clr_last;
    logic idx_bad;
    logic hit;
    logic lim0;
    logic cnt_last;
    logic out_free;
  } flags_t;

  localparam ucode_t UC_NOP = '{
    s_ready: 1'b0, in_ld: 1'b0, cond: CND_ALWAYS, jmp: P_IDLE, nxt: P_IDLE,
    ra: RA_IDX, wr: WR_NONE, pos: POS_HOLD, cnt_ld: 1'b0, cnt_dec: 1'b0,
    cap: CAP_NONE, res: RES_NONE, mul_ld: 1'b0, clr_inc: 1'b0, out_ld: 1'b0
  };

  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    w = UC_NOP;
    unique case (s)
      P_IDLE: begin
        w.s_ready = 1'b1;
        w.in_ld   = 1'b1;
        w.cond    = CND_BEAT;
        w.nxt     = P_IDLE;
      end
      P_SMP_MUL: begin
        w.mul_ld = 1'b1;
        w.jmp    = P_SMP_WR;
      end
      P_SMP_WR: begin
        w.wr  = WR_SAMPLE;
        w.jmp = P_IDLE;
      end
      P_CLR: begin
        w.wr      = WR_CLEAR;
        w.clr_inc = 1'b1;
        w.cond    = CND_CLR_LAST;
        w.jmp     = P_IDLE;
        w.nxt     = P_CLR;
      end
      P_Q0: begin
        w.ra   = RA_IDX;
        w.cond = CND_IDX_BAD;
        w.jmp  = P_EMPTY;
        w.nxt  = P_Q1;
      end
      P_Q1: begin
        w.cap  = CAP_VAL;
        w.cond = CND_HIT;
        w.jmp  = P_MEAS;
        w.nxt  = P_FI;
      end
      P_FI: begin
        w.ra     = RA_NEXT_IDX;
        w.pos    = POS_NEXT_IDX;
        w.cnt_ld = 1'b1;
        w.cond   = CND_LIM0;
        w.jmp    = P_EMPTY;
        w.nxt    = P_FWD;
      end
      P_FWD: begin
        w.ra      = RA_NEXT_POS;
        w.pos     = POS_NEXT;
        w.cnt_dec = 1'b1;
        w.cap     = CAP_FWD;
        w.cond    = CND_HIT_LOOP;
        w.jmp     = P_BI;
        w.nxt     = P_EMPTY;
      end
      P_BI: begin
        w.ra     = RA_PREV_IDX;
        w.pos    = POS_PREV_IDX;
        w.cnt_ld = 1'b1;
        w.jmp    = P_BWD;
      end
      P_BWD: begin
        w.ra      = RA_PREV_POS;
        w.pos     = POS_PREV;
        w.cnt_dec = 1'b1;
        w.cap     = CAP_VAL;
        w.cond    = CND_HIT_LOOP;
        w.jmp     = P_AVG;
        w.nxt     = P_EMPTY;
      end
      P_AVG: begin
        w.res = RES_AVG;
        w.jmp = P_OUT;
      end
      P_MEAS: begin
        w.res = RES_MEAS;
        w.jmp = P_OUT;
      end
      P_EMPTY: begin
        w.res = RES_EMPTY;
        w.jmp = P_OUT;
      end
      P_OUT: begin
        w.out_ld = 1'b1;
        w.cond   = CND_OUT_FREE;
        w.jmp    = P_IDLE;
        w.nxt    = P_OUT;
      end
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

  function automatic step_e dispatch(logic [OP_W-1:0] op);
    step_e s;
    unique case (op)
      OP_SAMPLE: s = P_SMP_MUL;
      OP_QUERY:  s = P_Q0;
      OP_CLEAR:  s = P_CLR;
      default:   s = P_IDLE;
    endcase
    return s;
  endfunction

  function automatic logic [BIN_W-1:0] bin_next(logic [BIN_W-1:0] p);
    return (p == BIN_W'(BIN_MAX)) ? '0 : p + BIN_W'(1);
  endfunction

  function automatic logic [BIN_W-1:0] bin_prev(logic [BIN_W-1:0] p);
    return (p == '0) ? BIN_W'(BIN_MAX) : p - BIN_W'(1);
  endfunction

endpackage

### hdl/lidar_scan_binning_gap_fill.sv
// Polar scan binning with gap fill on query: datapath, bin store and stream ports.
// Sample beat: accept, multiply, write. Clear beat: accept, then a sweep that writes every bin empty.
// Query beat: accept, read; a measured bin gives its value, an out-of-range bin an empty
// result, others a fill of up to search_reach bins per side; the walk reads one bin per cycle from
// the single-read bin RAM. One item is in work at a time; a result that finds the output
// register still full holds the sequencer in its output step until that beat drains.
// Reset: a clearing pass writes every bin empty; no beat is taken until done.
module lidar_scan_binning_gap_fill
  import lsbgf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // angle_q14, dist_q2, quality, sync_flag, bin_index (from bit 0 up), zero padded
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,
  // Results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // distance, zero padded
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // bin_status
  output logic [M_TUSER_W-1:0]  m_axis_tuser,
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ucode_t uc;
  flags_t flags;

  logic [THR_W-1:0]   thr_q;
  logic [REACH_W-1:0] reach_q;

  logic [ANGLE_W-1:0]   angle_q;
  logic [DIST_IN_W-1:0] dist_in_q;
  logic [QUAL_W-1:0]    qual_q;
  logic [FLAG_W-1:0]    flag_q;
  logic [IDX_W-1:0]     idx_q;

  logic [DEG_PROD_W-1:0] deg_prod_q;
  logic [DIV_PROD_W-1:0] div_prod_q;
  logic [DEG_W-1:0]      deg;
  logic [BIN_W-1:0]      smp_bin;
  logic                  smp_ok;

  logic [BIN_W-1:0]   clr_q;
  logic [BIN_W-1:0]   pos_q, pos_d;
  logic [REACH_W-1:0] cnt_q, cnt_d;
  logic [REACH_W-1:0] lim;
  logic [BIN_W-1:0]   idx_a;

  logic [DIST_W-1:0] fwd_q, val_q;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] res_dist_q;
  bin_status_e       res_st_q;

  logic              m_valid_q;
  logic [DIST_W-1:0] m_dist_q;
  bin_status_e       m_st_q;

  logic             ram_we;
  logic [BIN_W-1:0] ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;

  logic beat;
  logic out_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      reach_q <= REACH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_QUAL_THR) begin
        thr_q <= cfg_data_i[THR_W-1:0];
      end else if (cfg_idx_i == CFG_REACH) begin
        reach_q <= cfg_data_i[REACH_W-1:0];
      end
    end
  end

  assign s_axis_tready = uc.s_ready;
  assign beat          = s_axis_tvalid & uc.s_ready;
  assign out_free      = ~m_valid_q | m_axis_tready;

  // Search length per side, capped at BIN_MAX bins
  assign lim   = (int'(reach_q) > BIN_MAX) ? REACH_W'(BIN_MAX) : reach_q;
  assign idx_a = BIN_W'(idx_q);

  assign flags.beat     = beat;
  assign flags.clr_last = (clr_q == BIN_W'(BIN_MAX));
  assign flags.idx_bad  = (CMP_W'(idx_q) >= CMP_W'(BIN_COUNT));
  assign flags.hit      = ram_rdata[DIST_W];
  assign flags.lim0     = (lim == '0);
  assign flags.cnt_last = (cnt_q == REACH_W'(1));
  assign flags.out_free = out_free;

  lsbgf_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_i    (s_axis_tuser[OP_W-1:0]),
    .uc_o    (uc)
  );

  // Input beat capture
  always_ff @(posedge clk_i) begin
    if (uc.in_ld && beat) begin
      angle_q   <= s_axis_tdata[OFS_ANGLE +: ANGLE_W];
      dist_in_q <= s_axis_tdata[OFS_DIST +: DIST_IN_W];
      qual_q    <= s_axis_tdata[OFS_QUAL +: QUAL_W];
      flag_q    <= s_axis_tdata[OFS_FLAG +: FLAG_W];
      idx_q     <= s_axis_tdata[OFS_IDX +: IDX_W];
    end
  end

  // Sample products: degree scale and divide by 40
  always_ff @(posedge clk_i) begin
    if (uc.mul_ld) begin
      deg_prod_q <= angle_q * DEG_SCALE_W'(DEG_SCALE);
      div_prod_q <= dist_in_q[DIST_IN_W-1:DIV_PRE_SHIFT] * DIV5_MUL_W'(DIV5_MUL);
    end
  end

  assign deg     = deg_prod_q[DEG_PROD_W-1:DEG_FRAC];
  // Mirror: degree 0 stays, degree d lands in bin BIN_COUNT - d
  assign smp_bin = (deg == '0) ? '0 : BIN_W'(CMP_W'(BIN_COUNT) - CMP_W'(deg));
  assign smp_ok  = (flag_q == '0) && (qual_q >= thr_q) &&
                   (CMP_W'(deg) < CMP_W'(BIN_COUNT));

  // Bin RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    unique case (uc.wr)
      WR_SAMPLE: begin
        ram_we    = smp_ok;
        ram_waddr = smp_bin;
        ram_wdata = {1'b1, div_prod_q[DIV5_SHIFT +: DIST_W]};
      end
      WR_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Bin RAM read address
  always_comb begin
    unique case (uc.ra)
      RA_IDX:      ram_raddr = idx_a;
      RA_NEXT_IDX: ram_raddr = bin_next(idx_a);
      RA_PREV_IDX: ram_raddr = bin_prev(idx_a);
      RA_NEXT_POS: ram_raddr = bin_next(pos_q);
      RA_PREV_POS: ram_raddr = bin_prev(pos_q);
      default:     ram_raddr = idx_a;
    endcase
  end

  lsbgf_ram #(
    .WIDTH (MEM_W),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Clear sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (uc.clr_inc) begin
      clr_q <= flags.clr_last ? '0 : clr_q + BIN_W'(1);
    end
  end

  // Walk position and remaining count
  always_comb begin
    unique case (uc.pos)
      POS_NEXT_IDX: pos_d = bin_next(idx_a);
      POS_PREV_IDX: pos_d = bin_prev(idx_a);
      POS_NEXT:     pos_d = bin_next(pos_q);
      POS_PREV:     pos_d = bin_prev(pos_q);
      default:      pos_d = pos_q;
    endcase
    priority if (uc.cnt_ld) begin
      cnt_d = lim;
    end else if (uc.cnt_dec) begin
      cnt_d = cnt_q - REACH_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cnt_q <= cnt_d;
  end

  // Capture bin values seen by the walk
  always_ff @(posedge clk_i) begin
    unique case (uc.cap)
      CAP_FWD: fwd_q <= ram_rdata[DIST_W-1:0];
      CAP_VAL: val_q <= ram_rdata[DIST_W-1:0];
      default: ;
    endcase
  end

  assign sum = {1'b0, fwd_q} + {1'b0, val_q};

  // Result formation
  always_ff @(posedge clk_i) begin
    unique case (uc.res)
      RES_MEAS: begin
        res_dist_q <= val_q;
        res_st_q   <= ST_MEASURED;
      end
      RES_AVG: begin
        if ((fwd_q != '0) && (val_q != '0)) begin
          res_dist_q <= sum[DIST_W:1];
          res_st_q   <= ST_FILLED;
        end else begin
          res_dist_q <= '0;
          res_st_q   <= ST_EMPTY;
        end
      end
      RES_EMPTY: begin
        res_dist_q <= '0;
        res_st_q   <= ST_EMPTY;
      end
      default: ;
    endcase
  end

  // Output register: load when free or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (uc.out_ld && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.out_ld && out_free) begin
      m_dist_q <= res_dist_q;
      m_st_q   <= res_st_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(m_dist_q);
  assign m_axis_tuser  = M_TUSER_W'(m_st_q);

endmodule

### hdl/lsbgf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsbgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/lsbgf_useq.sv
// Microprogram sequencer: step counter, control table lookup and conditional jumps.
module lsbgf_useq
  import lsbgf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  flags_t          flags_i,
  input  logic [OP_W-1:0] op_i,
  output ucode_t          uc_o
);

  step_e  pc_q, pc_d;
  ucode_t uc;
  logic   take;

  assign uc   = ucode_rom(pc_q);
  assign uc_o = uc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= P_CLR;  // sweep the bins after reset
    end else begin
      pc_q <= pc_d;
    end
  end

  always_comb begin
    take = 1'b0;
    pc_d = uc.nxt;
    unique case (uc.cond)
      CND_ALWAYS:   pc_d = uc.jmp;
      CND_BEAT:     pc_d = flags_i.beat ? dispatch(op_i) : uc.nxt;
      CND_HIT_LOOP: begin
        if (flags_i.hit) begin
          pc_d = uc.jmp;
        end else if (flags_i.cnt_last) begin
          pc_d = uc.nxt;
        end else begin
          pc_d = pc_q;
        end
      end
      CND_CLR_LAST, CND_IDX_BAD, CND_HIT, CND_LIM0, CND_OUT_FREE: begin
        unique case (uc.cond)
          CND_CLR_LAST: take = flags_i.clr_last;
          CND_IDX_BAD:  take = flags_i.idx_bad;
          CND_HIT:      take = flags_i.hit;
          CND_LIM0:     take = flags_i.lim0;
          default:      take = flags_i.out_free;
        endcase
        pc_d = take ? uc.jmp : uc.nxt;
      end
      default: pc_d = P_IDLE;
    endcase
  end

endmodule

### verif/scan_bin_checker.sv
// Result checker for the scan binning block: tracks the bin store and compares query answers.
`timescale 1ns / 1ps

module scan_bin_checker
  import lsbgf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [S_TDATA_W-1:0]  s_data_i,
  input  logic [S_TUSER_W-1:0]  s_user_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [M_TDATA_W-1:0]  m_data_i,
  input  logic [M_TUSER_W-1:0]  m_user_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam int DIST_DIV = 40;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    bin_status_e       status;
  } bin_answer_t;

  bin_answer_t        answers_due[$];
  logic [DIST_W-1:0]  bin_dist [BIN_COUNT];
  logic               bin_meas [BIN_COUNT];
  logic [THR_W-1:0]   qual_thr;
  logic [REACH_W-1:0] reach;
  int                 errors;

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic void clear_bins();
    for (int b = 0; b < BIN_COUNT; b++) begin
      bin_dist[b] = '0;
      bin_meas[b] = 1'b0;
    end
  endfunction

  // Walk away from a bin, wrapping around, until a measured bin or the reach runs out.
  function automatic logic seek_measured(input int from, input bit upward,
                                         output logic [DIST_W-1:0] found);
    int steps;
    int pos;
    steps = int'(reach);
    if (steps > BIN_MAX) steps = BIN_MAX;
    pos = from;
    found = '0;
    for (int k = 0; k < steps; k++) begin
      if (upward) pos = (pos == BIN_MAX) ? 0 : pos + 1;
      else pos = (pos == 0) ? BIN_MAX : pos - 1;
      if (bin_meas[pos]) begin
        found = bin_dist[pos];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bin_answer_t answer_query(input logic [IDX_W-1:0] idx);
    bin_answer_t       a;
    logic [DIST_W-1:0] up_val;
    logic [DIST_W-1:0] down_val;
    logic              up_hit;
    logic              down_hit;
    a.distance = '0;
    a.status   = ST_EMPTY;
    if (int'(idx) < BIN_COUNT) begin
      if (bin_meas[idx]) begin
        a.distance = bin_dist[idx];
        a.status   = ST_MEASURED;
      end else begin
        up_hit   = seek_measured(int'(idx), 1'b1, up_val);
        down_hit = seek_measured(int'(idx), 1'b0, down_val);
        // a measured zero on either side blocks the fill
        if (up_hit && down_hit && up_val != '0 && down_val != '0) begin
          a.distance = DIST_W'((int'(up_val) + int'(down_val)) >> 1);
          a.status   = ST_FILLED;
        end
      end
    end
    return a;
  endfunction

  function automatic void store_sample(input logic [ANGLE_W-1:0] angle,
                                       input logic [DIST_IN_W-1:0] dist_val,
                                       input logic [QUAL_W-1:0] qual,
                                       input logic [FLAG_W-1:0] flag);
    int deg;
    int b;
    if (flag != '0 || qual < qual_thr) return;
    deg = (int'(angle) * DEG_SCALE) >> DEG_FRAC;
    if (deg >= BIN_COUNT) return;
    // mirror: degree d lands in bin BIN_COUNT - d, degree 0 stays put
    b = (deg == 0) ? 0 : BIN_COUNT - deg;
    bin_dist[b] = DIST_W'(int'(dist_val) / DIST_DIV);
    bin_meas[b] = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bin_answer_t want;
    if (!rst_ni) begin
      clear_bins();
      qual_thr = THR_RESET;
      reach    = REACH_RESET;
      answers_due.delete();
      errors = 0;
    end else begin
      // results leaving this edge belong to queries taken earlier, so check first
      if (m_valid_i && m_ready_i) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result beat with none due (distance %0d, status %0d)",
                                    m_data_i[DIST_W-1:0], m_user_i));
        end else begin
          want = answers_due.pop_front();
          if (m_data_i[DIST_W-1:0] != want.distance)
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      m_data_i[DIST_W-1:0], want.distance));
          if (m_user_i != want.status)
            report_mismatch($sformatf("bin_status %0d, expected %0d",
                                      m_user_i, want.status));
        end
      end
      if (s_valid_i && s_ready_i) begin
        case (s_user_i)
          OP_SAMPLE: store_sample(s_data_i[OFS_ANGLE +: ANGLE_W], s_data_i[OFS_DIST +: DIST_IN_W],
                                  s_data_i[OFS_QUAL +: QUAL_W], s_data_i[OFS_FLAG +: FLAG_W]);
          OP_QUERY:  answers_due.push_back(answer_query(s_data_i[OFS_IDX +: IDX_W]));
          OP_CLEAR:  clear_bins();
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QUAL_THR: qual_thr = cfg_data_i[THR_W-1:0];
          CFG_REACH:    reach = cfg_data_i[REACH_W-1:0];
          default: ;
        endcase
      end
    end
    errors_o  <= errors;
    pending_o <= answers_due.size();
  end

endmodule

### verif/testbench.sv
// Top of the scan binning testbench: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps

module testbench;
  import lsbgf_pkg::*;

  localparam int PHASE_ITEMS   = 500;
  localparam int SETTLE_CYCLES = BIN_COUNT + 40;
  localparam int LIMIT_CYCLES  = 4000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int cycles = 0;
  int src_idle_pct = 24;
  int sink_idle_pct = 50;
  int qual_floor = int'(THR_RESET);
  int reach_now = int'(REACH_RESET);

  lidar_scan_binning_gap_fill dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  scan_bin_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_tvalid),
    .s_ready_i  (s_tready),
    .s_data_i   (s_tdata),
    .s_user_i   (s_tuser),
    .m_valid_i  (m_tvalid),
    .m_ready_i  (m_tready),
    .m_data_i   (m_tdata),
    .m_user_i   (m_tuser),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Lowest angle whose whole degree is deg.
  function automatic logic [ANGLE_W-1:0] angle_for_degree(input int deg);
    return ANGLE_W'(((deg << DEG_FRAC) + DEG_SCALE - 1) / DEG_SCALE);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ANGLE_W-1:0] angle,
                           input logic [DIST_IN_W-1:0] dist_val, input logic [QUAL_W-1:0] qual,
                           input logic [FLAG_W-1:0] flag, input logic [IDX_W-1:0] idx);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 6);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata = '0;
    s_tdata[OFS_ANGLE +: ANGLE_W] = angle;
    s_tdata[OFS_DIST +: DIST_IN_W] = dist_val;
    s_tdata[OFS_QUAL +: QUAL_W] = qual;
    s_tdata[OFS_FLAG +: FLAG_W] = flag;
    s_tdata[OFS_IDX +: IDX_W] = idx;
    s_tuser = op;
    s_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_sample(input int deg, input logic [DIST_IN_W-1:0] dist_val,
                             input logic [QUAL_W-1:0] qual, input logic [FLAG_W-1:0] flag);
    send_item(OP_SAMPLE, angle_for_degree(deg), dist_val, qual, flag, IDX_W'($urandom));
  endtask

  task automatic send_query(input logic [IDX_W-1:0] idx);
    send_item(OP_QUERY, ANGLE_W'($urandom), DIST_IN_W'($urandom), QUAL_W'($urandom),
              FLAG_W'($urandom), idx);
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, ANGLE_W'($urandom), DIST_IN_W'($urandom), QUAL_W'($urandom),
              FLAG_W'($urandom), IDX_W'($urandom));
  endtask

  // Hold the input until every answer is out; optionally let a trailing clear finish too.
  task automatic drain(input bit settle);
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic retune(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] reach_data,
                        input int src_pct, input int sink_pct);
    drain(1'b1);
    cfg_we = 1'b1;
    cfg_idx = CFG_QUAL_THR;
    cfg_data = thr;
    @(negedge clk_i);
    cfg_idx = CFG_REACH;
    cfg_data = reach_data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    qual_floor = int'(thr);
    reach_now = int'(reach_data[REACH_W-1:0]);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // Scans: an optional clear, a burst of mostly samples packed into an angular window, then mostly queries around it.
  task automatic run_scans(input int budget);
    int sent;
    int center;
    int width;
    int deg;
    int r;
    int base;
    logic [DIST_IN_W-1:0] dist_val;
    logic [QUAL_W-1:0] qual;
    logic [FLAG_W-1:0] flag;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 40) begin
        send_clear();
        sent++;
      end
      center = $urandom_range(0, BIN_MAX);
      width = ($urandom_range(9) == 0) ? BIN_MAX : $urandom_range(0, 24);
      base = BIN_COUNT - center - width - reach_now - 2;
      repeat ($urandom_range(3, 30)) begin
        r = $urandom_range(99);
        if (r < 3) begin
          send_item(OP_UNUSED, ANGLE_W'($urandom), DIST_IN_W'($urandom), QUAL_W'($urandom),
                    FLAG_W'($urandom), IDX_W'($urandom));
        end else if (r < 8) begin
          send_item(OP_SAMPLE, ANGLE_W'($urandom), DIST_IN_W'($urandom), QUAL_W'($urandom),
                    FLAG_W'($urandom), IDX_W'($urandom));
          sent++;
        end else begin
          deg = (center + $urandom_range(0, width)) % BIN_COUNT;
          r = $urandom_range(99);
          if (r < 10) dist_val = DIST_IN_W'($urandom_range(0, 39));
          else if (r < 15) dist_val = DIST_IN_W'(262143 - $urandom_range(0, 100));
          else dist_val = DIST_IN_W'($urandom_range(40, 262143));
          qual = ($urandom_range(99) < 85) ? QUAL_W'($urandom_range(qual_floor, 255))
                                           : QUAL_W'($urandom);
          flag = ($urandom_range(99) < 90) ? '0 : FLAG_W'($urandom_range(1, 255));
          send_item(OP_SAMPLE, angle_for_degree(deg) + ANGLE_W'($urandom_range(0, 150)),
                    dist_val, qual, flag, IDX_W'($urandom));
          sent++;
        end
      end
      repeat ($urandom_range(3, 20)) begin
        r = $urandom_range(99);
        if (r < 2) drain(1'b0);
        if (r < 5) send_query(IDX_W'($urandom_range(0, 511)));
        else if (r < 12) send_query(IDX_W'($urandom_range(0, BIN_MAX)));
        else if (r < 22) begin
          deg = (center + $urandom_range(0, width)) % BIN_COUNT;
          send_sample(deg, DIST_IN_W'($urandom_range(0, 262143)),
                      QUAL_W'($urandom_range(qual_floor, 255)), '0);
        end else begin
          send_query(IDX_W'((base + $urandom_range(0, width + 2 * reach_now + 4) + 2 * BIN_COUNT)
                            % BIN_COUNT));
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: threshold 60, reach 8
    send_query(IDX_W'(0));
    send_sample(0, 18'h3FFFF, 8'd255, 8'd0);
    send_item(OP_SAMPLE, 16'hFFFF, 18'd39, 8'd60, 8'd0, 9'd0);  // measured zero in bin 1
    send_sample(10, 18'd5000, 8'd59, 8'd0);
    send_sample(10, 18'd5000, 8'd200, 8'hFF);
    send_sample(5, 18'd4000, 8'd61, 8'd0);
    send_sample(355, 18'd8000, 8'd61, 8'd0);
    send_query(IDX_W'(0));
    send_query(IDX_W'(1));
    send_query(IDX_W'(350));
    send_query(IDX_W'(358));  // fill across the wrap
    send_query(IDX_W'(3));    // blocked by the measured zero
    send_query(IDX_W'(BIN_COUNT));
    send_query(9'h1FF);
    send_item(OP_UNUSED, 16'hFFFF, 18'h3FFFF, 8'hFF, 8'hFF, 9'h1FF);
    send_sample(5, 18'd40, 8'd255, 8'd0);
    send_query(IDX_W'(355));
    send_query(IDX_W'(180));
    send_clear();
    send_query(IDX_W'(0));

    retune(8'd0, 8'd0, 24, 50);
    send_sample(1, 18'd400, 8'd0, 8'd0);
    send_sample(359, 18'd400, 8'd0, 8'd0);
    send_sample(100, 18'd400, 8'd0, 8'd1);
    send_query(IDX_W'(0));
    send_query(IDX_W'(260));

    // top data bit is dropped: reach becomes 127
    retune(8'd255, 8'hFF, 24, 50);
    send_sample(90, 18'd800, 8'd254, 8'd0);
    send_sample(200, 18'd1200, 8'd255, 8'd0);
    send_sample(300, 18'd2000, 8'd255, 8'd0);
    send_query(IDX_W'(110));
    send_query(IDX_W'(270));

    retune(8'd60, 8'd8, 24, 50);
    run_scans(PHASE_ITEMS);
    retune(8'd0, 8'hC0, 50, 24);
    run_scans(PHASE_ITEMS);
    retune(8'd255, 8'd1, 0, 0);
    run_scans(PHASE_ITEMS);
    retune(8'd100, 8'd3, 0, 0);
    run_scans(PHASE_ITEMS);

    drain(1'b1);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lsbgf_pkg.sv
hdl/lsbgf_ram.sv
hdl/lsbgf_useq.sv
hdl/lidar_scan_binning_gap_fill.sv
verif/scan_bin_checker.sv
verif/testbench.sv
